/* design/tse_pkg.sv */
package tse_pkg;

   localparam int TAB_STOP_DEFAULT = 8;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_VXT_MODE = 1'b0;

   localparam logic [7:0] CODE_NUL    = 8'd0;
   localparam logic [7:0] CODE_TAB    = 8'd9;
   localparam logic [7:0] CODE_LF     = 8'd10;
   localparam logic [7:0] CODE_CR     = 8'd13;
   localparam logic [7:0] CODE_SPACE  = 8'd32;
   localparam logic [7:0] CTRL_END    = 8'o20;
   localparam logic [7:0] PRINT_BASE  = 8'o40;
   localparam logic [7:0] REP_BASE    = 8'o200;
   localparam logic [7:0] REP_END     = 8'o240;
   localparam logic [7:0] SHIFT_LIMIT = 8'o140;
   localparam logic [7:0] SHIFT_ADD   = 8'o40;

   localparam logic [7:0] VXT_TAB_SPACES = 8'd8;
   localparam logic [7:0] RUN_MAX        = 8'd127;

   typedef struct packed {
      logic [7:0] char_code;
      logic [6:0] run_length;
      logic       run_end;
   } rsp_item_type;

endpackage

/* design/bk_text_space_tab_expander.sv */
// Packed text expander: one file byte in, up to two runs (code, count) out.
// Input channel req_*: valid/ready, one byte per item with a last-byte mark.
// Result channel rsp_*: valid/ready, one run per item; run_end marks the last
// run caused by a byte. A line end gives two runs (CR then LF).
// Config port csr_*: APB-style, one register (vxt_mode) at address 0; write
// it only while the block is idle.
// An accepted byte waits in the input register and its runs go into the result
// queue once they fit. Throughput: one byte per cycle while the queue has room;
// a line-end byte puts two runs on the single result port.
// The byte sits in an input register; the run generator and column update
// are one pass of logic into a two-entry result queue.
// Reset: column, count flag and pending repeat are cleared, vxt_mode is 0,
// both channels are empty. The state is also cleared after each last byte.
// Receiver stall: the queue holds up to two runs and the input register one
// byte; req_ready drops once the next byte's runs do not fit.
module bk_text_space_tab_expander #(
   parameter int TAB_STOP = tse_pkg::TAB_STOP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_is_final,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_char_code,
   output logic [6:0]                    rsp_run_length,
   output logic                          rsp_run_end,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import tse_pkg::*;

   localparam int ColW = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

   logic              vxt_ff;
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_final_ff;
   logic [ColW-1:0]   col_ff, col_in;
   logic              flag_ff, flag_in;
   logic [4:0]        pend_ff, pend_in;
   rsp_item_type      q_ff [2];
   rsp_item_type      q_in [2];
   logic [1:0]        cnt_ff, cnt_in;

   logic [ColW-1:0]   mod_tbl [128];
   rsp_item_type      r0, r1;
   logic [1:0]        nres;
   logic              pop, move;
   logic [1:0]        cnt_pop;
   logic              csr_write;

   for (genvar i = 0; i < 128; i++) begin : g_mod
      localparam int ModVal = i % TAB_STOP;
      assign mod_tbl[i] = ColW'(ModVal);
   end

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_VXT_MODE) ? {31'd0, vxt_ff} : 32'd0;

   always_comb begin
      logic [7:0] b;
      logic [7:0] len;
      logic [7:0] stop_dist;
      logic [7:0] code;
      logic       one;
      logic       col_zero;
      b         = in_byte_ff;
      stop_dist = 8'(TAB_STOP) - 8'(col_ff);
      len       = 8'd1;
      code      = b;
      one       = 1'b0;
      col_zero  = 1'b0;
      nres      = 2'd0;
      flag_in   = flag_ff;
      pend_in   = pend_ff;
      if (vxt_ff) begin
         pend_in = 5'd0;
         if (in_final_ff) begin
            nres = 2'd0;
         end else if (b == CODE_NUL || b == CODE_LF) begin
            nres     = 2'd2;
            col_zero = 1'b1;
            flag_in  = 1'b0;
         end else if (b < CODE_TAB) begin
            one  = 1'b1;
            code = CODE_SPACE;
            if (flag_ff) begin
               len = 8'(b[3:0]) * VXT_TAB_SPACES;
            end else begin
               len     = b;
               flag_in = 1'b1;
            end
         end else begin
            flag_in = 1'b0;
            if (b == CODE_TAB) begin
               one      = 1'b1;
               code     = CODE_SPACE;
               len      = stop_dist;
               col_zero = 1'b1;
            end else if (b >= PRINT_BASE) begin
               one = 1'b1;
            end
         end
      end else begin
         if (pend_ff != 5'd0) begin
            one     = 1'b1;
            len     = 8'(pend_ff);
            code    = (b < SHIFT_LIMIT) ? b + SHIFT_ADD : b;
            pend_in = 5'd0;
            flag_in = 1'b0;
         end else if (b == CODE_NUL || b == CODE_LF) begin
            nres     = 2'd2;
            col_zero = 1'b1;
            flag_in  = 1'b0;
         end else if (b == CODE_TAB) begin
            one      = 1'b1;
            code     = CODE_SPACE;
            len      = stop_dist;
            col_zero = 1'b1;
         end else if (b < CTRL_END) begin
            one  = 1'b1;
            code = CODE_SPACE;
            if (flag_ff) begin
               len      = stop_dist + (8'(b[3:0]) - 8'd1) * 8'(TAB_STOP);
               col_zero = 1'b1;
               flag_in  = 1'b0;
            end else begin
               len     = b;
               flag_in = 1'b1;
            end
         end else if (b < PRINT_BASE) begin
            nres = 2'd0;
         end else if (b > REP_BASE && b < REP_END) begin
            pend_in = b[4:0];
         end else begin
            one     = 1'b1;
            flag_in = 1'b0;
         end
      end
      if (one) begin
         nres = 2'd1;
      end
      if (nres == 2'd2) begin
         r0 = '{char_code: CODE_CR, run_length: 7'd1, run_end: 1'b0};
         r1 = '{char_code: CODE_LF, run_length: 7'd1, run_end: 1'b1};
      end else begin
         r0 = '{char_code: code,
                run_length: (len > RUN_MAX) ? RUN_MAX[6:0] : len[6:0],
                run_end: 1'b1};
         r1 = r0;
      end
      if (col_zero || nres == 2'd2) begin
         col_in = '0;
      end else if (nres == 2'd1) begin
         col_in = mod_tbl[7'(col_ff) + len[6:0]];
      end else begin
         col_in = col_ff;
      end
      if (in_final_ff) begin
         col_in  = '0;
         flag_in = 1'b0;
         pend_in = 5'd0;
      end
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_char_code  = q_ff[0].char_code;
   assign rsp_run_length = q_ff[0].run_length;
   assign rsp_run_end    = q_ff[0].run_end;

   assign pop       = rsp_valid && rsp_ready;
   assign cnt_pop   = cnt_ff - {1'b0, pop};
   assign move      = in_valid_ff && ((3'(cnt_pop) + 3'(nres)) <= 3'd2);
   assign req_ready = !in_valid_ff || move;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_pop;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (move && nres != 2'd0) begin
         cnt_in = cnt_pop + nres;
         if (cnt_pop == 2'd0) begin
            q_in[0] = r0;
            q_in[1] = r1;
         end else begin
            q_in[1] = r0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vxt_ff      <= 1'b0;
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         col_ff      <= '0;
         flag_ff     <= 1'b0;
         pend_ff     <= 5'd0;
      end else begin
         if (csr_write && csr_paddr[2] == CSR_IDX_VXT_MODE) begin
            vxt_ff <= csr_pwdata[0];
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         cnt_ff <= cnt_in;
         if (move) begin
            col_ff  <= col_in;
            flag_ff <= flag_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_is_final;
      end
      q_ff <= q_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("result queue overfilled");

   a_cr_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |-> cnt_ff == 2'd2)
      else $error("line-end run without its partner in queue");

   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      move && in_final_ff |=> col_ff == '0 && !flag_ff && pend_ff == 5'd0)
      else $error("state not cleared after last byte");

   a_vxt_no_pend: assert property (@(posedge clock) disable iff (reset)
      move && vxt_ff |=> pend_ff == 5'd0)
      else $error("repeat pending in vxt mode");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length != 7'd0)
      else $error("zero-length run");

endmodule

/* dv/bk_text_space_tab_expander_tb.sv */
`timescale 1ns / 1ps

module bk_text_space_tab_expander_tb;
   import tse_pkg::*;

   localparam int TAB = TAB_STOP_DEFAULT;
   localparam logic [7:0] REP_MASK = 8'o37;
   localparam logic [CSR_ADDR_W-1:0] VXT_MODE_ADDR = CSR_ADDR_W'({CSR_IDX_VXT_MODE, 2'b00});
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 190;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_is_final = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_char_code;
   logic [6:0]  rsp_run_length;
   logic        rsp_run_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rsp_item_type runs_due[$];
   rsp_item_type next_run;

   logic vxt_on = 1'b0;
   int   col_phase = 0;
   logic count_flag = 1'b0;
   int   repeat_left = 0;

   logic gaps_on = 1'b1;
   int   stall_left = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   bk_text_space_tab_expander DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_is_final   (req_is_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_run_length (rsp_run_length),
      .rsp_run_end    (rsp_run_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bk_text_space_tab_expander_tb: done, errors");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      if (error_count < 10) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic queue_run(input logic [7:0] code, input int len, input logic last);
      rsp_item_type r;
      r.char_code = code;
      r.run_length = (len > int'(RUN_MAX)) ? 7'(RUN_MAX) : 7'(len);
      r.run_end = last;
      runs_due.push_back(r);
   endtask

   task automatic emit_single(input logic [7:0] code, input int len);
      queue_run(code, len, 1'b1);
      col_phase = (col_phase + len) % TAB;
   endtask

   task automatic emit_line_end();
      queue_run(CODE_CR, 1, 1'b0);
      queue_run(CODE_LF, 1, 1'b1);
      col_phase = 0;
   endtask

   task automatic predict_runs(input logic [7:0] b, input logic fin);
      int n;
      logic [7:0] c;
      if (!vxt_on) begin
         if (repeat_left != 0) begin
            n = repeat_left;
            repeat_left = 0;
            c = (b < SHIFT_LIMIT) ? b + SHIFT_ADD : b;
            count_flag = 1'b0;
            emit_single(c, n);
         end else if (b == CODE_NUL || b == CODE_LF) begin
            count_flag = 1'b0;
            emit_line_end();
         end else if (b == CODE_TAB) begin
            emit_single(CODE_SPACE, TAB - col_phase);
         end else if (b < CTRL_END) begin
            if (count_flag) begin
               n = TAB - col_phase + (int'(b) - 1) * TAB;
               count_flag = 1'b0;
            end else begin
               n = int'(b);
               count_flag = 1'b1;
            end
            emit_single(CODE_SPACE, n);
         end else if (b < PRINT_BASE) begin
            // drop, count flag kept
         end else if (b > REP_BASE && b < REP_END) begin
            if (!fin) begin
               repeat_left = int'(b & REP_MASK);
            end
         end else begin
            count_flag = 1'b0;
            emit_single(b, 1);
         end
      end else if (!fin) begin
         repeat_left = 0;
         if (b == CODE_NUL || b == CODE_LF) begin
            count_flag = 1'b0;
            emit_line_end();
         end else if (b < CODE_TAB) begin
            if (count_flag) begin
               emit_single(CODE_SPACE, int'(b) * int'(VXT_TAB_SPACES));
            end else begin
               count_flag = 1'b1;
               emit_single(CODE_SPACE, int'(b));
            end
         end else begin
            count_flag = 1'b0;
            if (b == CODE_TAB) begin
               emit_single(CODE_SPACE, TAB - col_phase);
            end else if (b >= PRINT_BASE) begin
               emit_single(b, 1);
            end
         end
      end
      if (fin) begin
         col_phase = 0;
         count_flag = 1'b0;
         repeat_left = 0;
      end
   endtask

   always @(posedge clock) begin
      if (!gaps_on) begin
         stall_left <= 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (runs_due.size() == 0) begin
            flag_error($sformatf("unexpected run code=%0d len=%0d end=%0b",
                                 rsp_char_code, rsp_run_length, rsp_run_end));
         end else begin
            next_run = runs_due.pop_front();
            if (rsp_char_code !== next_run.char_code ||
                rsp_run_length !== next_run.run_length ||
                rsp_run_end !== next_run.run_end) begin
               flag_error($sformatf("run exp code=%0d len=%0d end=%0b, got code=%0d len=%0d end=%0b",
                                    next_run.char_code, next_run.run_length, next_run.run_end,
                                    rsp_char_code, rsp_run_length, rsp_run_end));
            end
         end
      end
   end

   task automatic send_char(input logic [7:0] b, input logic fin);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_is_final <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_runs(b, fin);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (runs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_mode(input logic mode);
      logic [31:0] rd;
      wait_idle();
      csr_write(VXT_MODE_ADDR, {31'd0, mode});
      vxt_on = mode;
      @(posedge clock);
      csr_read(VXT_MODE_ADDR, rd);
      if (rd[0] !== mode) begin
         flag_error($sformatf("vxt_mode readback exp %0b got %0b", mode, rd[0]));
      end
   endtask

   task automatic test_generic_rules();
      set_mode(1'b0);
      send_char(8'h41, 1'b0);
      send_char(CODE_NUL, 1'b0);
      send_char(CODE_TAB, 1'b0);
      send_char(8'd3, 1'b0);
      send_char(8'd20, 1'b0);
      send_char(8'd2, 1'b0);
      send_char(8'd15, 1'b0);
      send_char(8'd15, 1'b0);
      send_char(CODE_LF, 1'b0);
      send_char(8'o200, 1'b0);
      send_char(8'o201, 1'b0);
      send_char(8'h41, 1'b0);
      send_char(8'o237, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'o210, 1'b0);
      send_char(CODE_LF, 1'b0);
      send_char(8'o205, 1'b1);
      send_char(8'h20, 1'b1);
   endtask

   task automatic test_vxt_rules();
      set_mode(1'b1);
      send_char(8'd3, 1'b0);
      send_char(8'd8, 1'b0);
      send_char(CODE_TAB, 1'b0);
      send_char(8'd12, 1'b0);
      send_char(8'd5, 1'b0);
      send_char(8'o201, 1'b0);
      send_char(8'h5A, 1'b1);
   endtask

   task automatic test_vxt_drops_pending_repeat();
      set_mode(1'b0);
      send_char(8'o203, 1'b0);
      set_mode(1'b1);
      send_char(8'h61, 1'b0);
   endtask

   function automatic logic [7:0] pick_byte(input logic vxt);
      int k;
      k = $urandom_range(0, 99);
      if (k < 30) return 8'($urandom_range(32, 127));
      if (k < 36) return 8'($urandom_range(160, 255));
      if (k < 46) return $urandom_range(0, 1) ? CODE_LF : CODE_NUL;
      if (k < 54) return CODE_TAB;
      if (k < 70) return vxt ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 15));
      if (k < 80) return 8'($urandom_range(129, 159));
      if (k < 88) return 8'($urandom_range(11, 31));
      return 8'($urandom());
   endfunction

   task automatic test_random_files();
      logic mode;
      for (int p = 0; p < PHASES; p++) begin
         mode = (p % 2 == 1);
         gaps_on = (p < PHASES - 1) && ($urandom_range(0, 4) != 0);
         set_mode(mode);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_char(pick_byte(mode), $urandom_range(0, 29) == 0);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_generic_rules();
      test_vxt_rules();
      test_vxt_drops_pending_repeat();
      test_random_files();
      wait_idle();
      if (runs_due.size() != 0) begin
         flag_error($sformatf("%0d runs never arrived", runs_due.size()));
      end
      if (error_count == 0) begin
         $display("bk_text_space_tab_expander_tb: done, clean");
      end else begin
         $display("bk_text_space_tab_expander_tb: done, errors");
      end
      $finish;
   end

endmodule
